@@ src/wacrms_pkg.sv @@
// ----------------------------------------------------------------------------
// wacrms_pkg: shared definitions of the windowed AC RMS voltmeter
// Field widths, register codes, reset values and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package wacrms_pkg;

	localparam int unsigned WINDOW_LEN_DEF = 150;

	localparam int unsigned SAMPLE_W   = 12;
	localparam int unsigned GAIN_W     = 16;
	localparam int unsigned OUT_W      = 16;
	localparam int unsigned IN_TDATA_W = 16;
	localparam int unsigned SUM_W      = 20;
	localparam int unsigned SQ_W       = 32;
	localparam int unsigned ROOT_W     = 16;
	localparam int unsigned SREM_W     = 17;

	// Each quotient byte takes an estimate, then the remainder update.
	localparam int unsigned DIV_STEPS  = 8;
	localparam int unsigned SQRT_STEPS = 16;
	localparam int unsigned CNT_W      = 5;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [SAMPLE_W-1:0] OFFSET_RESET = 12'd2948;
	localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd14485;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ZERO_OFFSET = 2'd0,
		REG_VOLTS_GAIN  = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic mul;
		logic load_div;
		logic div_est;
		logic div_step;
		logic sqrt_step;
		logic scale;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic report;
	} status_t;

endpackage

`default_nettype wire

@@ src/wacrms_ram.sv @@
// ----------------------------------------------------------------------------
// wacrms_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wacrms_ram #(
	parameter int unsigned WIDTH = 12,
	parameter int unsigned DEPTH = 150
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ src/wacrms_ctrl.sv @@
// ----------------------------------------------------------------------------
// wacrms_ctrl: sequencer of the voltmeter
// Steps the datapath through the ring update and, on a report, through the
// offset terms, the long division, the square root and the gain scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module wacrms_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	input  wire wacrms_pkg::status_t status,
	output wacrms_pkg::cmd_t         cmd
);

	import wacrms_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_SQRT,
		ST_SCALE,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             m_tvalid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:   cmd.capture   = s_tvalid;
			ST_UPDATE: cmd.update    = 1'b1;
			ST_MUL:    cmd.mul       = 1'b1;
			ST_LOAD:   cmd.load_div  = 1'b1;
			ST_DIV: begin
				// Odd counts form the quotient byte estimate, even counts retire it.
				cmd.div_est  = cnt_q[0];
				cmd.div_step = !cnt_q[0];
			end
			ST_SQRT:   cmd.sqrt_step = 1'b1;
			ST_SCALE:  cmd.scale     = 1'b1;
			ST_DONE:   cmd.load_out  = !m_tvalid_q || m_tready;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= status.report ? ST_MUL : ST_IDLE;
				end
				ST_MUL: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
					cnt_q   <= CNT_W'(DIV_STEPS - 1);
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_SQRT;
						cnt_q   <= CNT_W'(SQRT_STEPS - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= ST_SCALE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_SCALE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (cmd.load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// The held result leaves on its transfer unless a new one replaces it.
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

endmodule

`default_nettype wire

@@ src/wacrms_dp.sv @@
// ----------------------------------------------------------------------------
// wacrms_dp: datapath of the voltmeter
// Sample ring, running sums, configuration registers, a reciprocal divider by
// the window length, a bit-serial square root and the gain multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module wacrms_dp #(
	parameter int unsigned WINDOW_LEN = wacrms_pkg::WINDOW_LEN_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire wacrms_pkg::cmd_t                     cmd,
	output wacrms_pkg::status_t                       status,
	input  wire logic [wacrms_pkg::SAMPLE_W-1:0]      sample,
	input  wire logic                                 report_now,
	input  wire logic                                 cfg_we,
	input  wire logic [wacrms_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [wacrms_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic      [wacrms_pkg::OUT_W-1:0]         voltage_q4
);

	import wacrms_pkg::*;

	localparam int unsigned SLOT_W  = $clog2(WINDOW_LEN);
	localparam int unsigned KW      = $clog2(WINDOW_LEN + 1);
	localparam int unsigned OO_W    = 2 * SAMPLE_W;
	localparam int unsigned DIG_W   = 8;
	localparam int unsigned DREM_W  = 8;
	localparam int unsigned DNUM_W  = DREM_W + DIG_W;
	localparam int unsigned RCP_SH  = 24;
	localparam int unsigned DPROD_W = DNUM_W + RCP_SH;
	localparam int unsigned DN_W    = 9;

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);
	localparam logic [KW-1:0]     WIN_K     = KW'(WINDOW_LEN);
	localparam logic [DN_W-1:0]   DIV_N     = DN_W'(WINDOW_LEN);
	// ceil(2^24 / N): exact quotient for every numerator below 2^16.
	localparam logic [RCP_SH-1:0] DIV_RCP   = RCP_SH'(((64'd1 << RCP_SH) +
		64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

	// Ring and running sums.
	logic [SAMPLE_W-1:0]   sample_q;
	logic                  report_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [WINDOW_LEN-1:0] valid_q;
	logic [SUM_W-1:0]      sum_q;
	logic [SQ_W-1:0]       sumsq_q;
	logic [SAMPLE_W-1:0]   ram_rdata;
	logic [SAMPLE_W-1:0]   old_sample;
	logic [OO_W-1:0]       old_sq;
	logic [OO_W-1:0]       new_sq;

	// Configuration.
	logic [SAMPLE_W-1:0] off_q;
	logic [GAIN_W-1:0]   gain_q;

	// Result path.
	logic [OO_W-1:0]     p_oo_s1;
	logic [SQ_W-1:0]     p_os_s1;
	logic [KW+OO_W-1:0]  n_oo;
	logic [SQ_W-1:0]     dev;
	logic [SQ_W-1:0]     shr_q;
	logic [DREM_W-1:0]   drem_q;
	logic [DNUM_W-1:0]   div_num;
	logic [DPROD_W-1:0]  div_prod;
	logic [DIG_W-1:0]    qd_q;
	logic [DNUM_W-1:0]   div_sub;
	logic [SREM_W-1:0]   srem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [SREM_W+1:0]   sq_acc;
	logic [SREM_W+1:0]   sq_trial;
	logic                sq_ge;
	logic [SQ_W-1:0]     prod_q;
	logic [SQ_W:0]       rounded;
	logic [OUT_W-1:0]    vout_q;

	wacrms_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(WINDOW_LEN)
	) u_ring (
		.clk  (clk),
		.we   (cmd.update),
		.waddr(slot_q),
		.wdata(sample_q),
		.re   (cmd.capture),
		.raddr(slot_q),
		.rdata(ram_rdata)
	);

	// Entries not yet written since reset count as zero samples.
	assign old_sample = valid_q[slot_q] ? ram_rdata : '0;
	assign old_sq     = old_sample * old_sample;
	assign new_sq     = sample_q * sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			valid_q <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			off_q   <= OFFSET_RESET;
			gain_q  <= GAIN_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_ZERO_OFFSET: off_q  <= cfg_data[SAMPLE_W-1:0];
					REG_VOLTS_GAIN:  gain_q <= cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.update) begin
				sum_q           <= sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
				sumsq_q         <= sumsq_q - SQ_W'(old_sq) + SQ_W'(new_sq);
				valid_q[slot_q] <= 1'b1;
				slot_q          <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_q <= 1'b0;
		end else if (cmd.capture) begin
			report_q <= report_now;
		end
	end

	// Sum of squared deviations over the window:
	// sum(x^2) + N*off^2 - 2*off*sum(x). The true value fits in 32 bits.
	assign n_oo = {{KW{1'b0}}, p_oo_s1} * {{OO_W{1'b0}}, WIN_K};
	assign dev  = sumsq_q + SQ_W'(n_oo) - {p_os_s1[SQ_W-2:0], 1'b0};

	// Long division one byte at a time. The partial remainder stays below N,
	// so each numerator is under N*256 and its quotient digit fits a byte.
	// The dividend shifts out at the top as quotient bytes shift in.
	assign div_num  = {drem_q, shr_q[SQ_W-1:SQ_W-DIG_W]};
	assign div_prod = DPROD_W'(div_num) * DPROD_W'(DIV_RCP);
	assign div_sub  = DNUM_W'(qd_q) * DNUM_W'(DIV_N);

	// One root bit per step from the top two bits of the quotient.
	assign sq_acc   = {srem_q, shr_q[SQ_W-1:SQ_W-2]};
	assign sq_trial = {1'b0, root_q, 2'b01};
	assign sq_ge    = (sq_acc >= sq_trial);

	assign rounded = {1'b0, prod_q} + (SQ_W + 1)'(32768);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= sample;
		end
		if (cmd.mul) begin
			p_oo_s1 <= off_q * off_q;
			p_os_s1 <= off_q * sum_q;
		end
		if (cmd.load_div) begin
			// dev*256 < N*2^32, so the bits above the quotient start below N.
			drem_q <= dev[SQ_W-1:SQ_W-DREM_W];
			shr_q  <= {dev[SQ_W-DIG_W-1:0], {DIG_W{1'b0}}};
			srem_q <= '0;
			root_q <= '0;
		end
		if (cmd.div_est) begin
			qd_q <= div_prod[RCP_SH+DIG_W-1:RCP_SH];
		end
		if (cmd.div_step) begin
			drem_q <= DREM_W'(div_num - div_sub);
			shr_q  <= {shr_q[SQ_W-DIG_W-1:0], qd_q};
		end
		if (cmd.sqrt_step) begin
			srem_q <= sq_ge ? SREM_W'(sq_acc - sq_trial) : sq_acc[SREM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], sq_ge};
			shr_q  <= {shr_q[SQ_W-3:0], 2'b00};
		end
		if (cmd.scale) begin
			prod_q <= root_q * gain_q;
		end
		if (cmd.load_out) begin
			vout_q <= rounded[SQ_W] ? {OUT_W{1'b1}} : rounded[SQ_W-1:SQ_W-OUT_W];
		end
	end

	assign status.report = report_q;
	assign voltage_q4    = vout_q;

endmodule

`default_nettype wire

@@ src/windowed_ac_rms_voltmeter.sv @@
// ----------------------------------------------------------------------------
// windowed_ac_rms_voltmeter: sliding-window AC RMS voltmeter
// Each sample replaces the oldest of WINDOW_LEN ring entries; on request the
// RMS deviation from a zero offset is scaled into volts.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive on the s_ channel, one per transfer, with tuser set when a
// voltage reading is wanted after this sample has been stored. Readings leave
// on the m_ channel in 1/16 V. The cfg_ channel writes the zero offset (index
// 0) and the Q0.16 volts gain (index 1); write it only while the block idles.
// A sample without a report needs the transfer, which also reads the ring,
// then the ring write and the sum update. With a report, the offset terms,
// the divide by the window length (a reciprocal estimate and a remainder
// update per quotient byte), the square root and the gain scaling follow;
// the reading is loaded into the output register before the next sample
// is taken.
// The result sits in an output register; new samples are taken while it
// waits. A second reading waits in the controller until the first leaves.
// Reset clears the sums and marks every ring entry empty, so an entry never
// written reads as zero; there is no clearing pass and samples are taken
// from the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_ac_rms_voltmeter #(
	parameter int unsigned WINDOW_LEN = wacrms_pkg::WINDOW_LEN_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	input  wire logic [wacrms_pkg::IN_TDATA_W-1:0]     s_tdata,  // [11:0] sample
	input  wire logic                                  s_tuser,  // [0] report_now
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	output logic      [wacrms_pkg::OUT_W-1:0]          m_tdata,  // [15:0] voltage_q4
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [wacrms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [wacrms_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import wacrms_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	wacrms_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.status  (status),
		.cmd     (cmd)
	);

	wacrms_dp #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.sample    (s_tdata[SAMPLE_W-1:0]),
		.report_now(s_tuser),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.voltage_q4(m_tdata)
	);

	// A new reading never overwrites one that is still waiting for its transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!m_tvalid || m_tready))
		else $error("reading loaded over a pending result");

	// The datapath performs at most one operation per cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.update, cmd.mul, cmd.load_div, cmd.div_est,
			cmd.div_step, cmd.sqrt_step, cmd.scale, cmd.load_out}))
		else $error("conflicting datapath commands");

	// The cycle after a sample transfer is spent on the ring update.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (cmd.update && !s_tready))
		else $error("sample transfer not followed by ring update");

endmodule

`default_nettype wire

@@ verif/tb_windowed_ac_rms_voltmeter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_windowed_ac_rms_voltmeter: self-checking bench of the AC RMS voltmeter
// Streams ADC samples with report requests into the block under bursty input
// and a stalling output. A bit-accurate model of the sample window, running
// sums and fixed-point RMS scaling predicts each reading. The bench compares
// every reading in order and goes through several zero-offset and gain
// settings, the extremes among them.
// ----------------------------------------------------------------------------

module tb_windowed_ac_rms_voltmeter;
	import wacrms_pkg::*;

	localparam int unsigned WINDOW     = WINDOW_LEN_DEF;
	localparam int unsigned SETTLE_CYC = 60;
	localparam int unsigned HOLD_CYC   = 400;
	localparam int unsigned LIMIT_CYC  = 1_000_000;
	localparam int unsigned ITEM_GOAL  = 1650;
	localparam int unsigned SAMPLE_MAX = 4095;

	// Register indexes the block does not decode.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [OUT_W-1:0]    volts_t;

	// Predicts voltage readings and holds those still due from the block.
	class volt_scoreboard;
		sample_t           ring [WINDOW];
		int unsigned       slot;
		logic [SUM_W-1:0]  lin_sum;
		logic [SQ_W-1:0]   sq_sum;
		sample_t           zero_code;
		logic [GAIN_W-1:0] gain;
		volts_t            pending [$];
		int unsigned       errors;

		function new();
			foreach (ring[i]) ring[i] = '0;
			slot = 0;
			lin_sum = '0;
			sq_sum = '0;
			zero_code = OFFSET_RESET;
			gain = GAIN_RESET;
			errors = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_ZERO_OFFSET: zero_code = data[SAMPLE_W-1:0];
				REG_VOLTS_GAIN:  gain = data[GAIN_W-1:0];
				default: ;
			endcase
		endfunction

		// Largest r with r*r <= v, found one bit at a time from the top.
		function logic [63:0] floor_sqrt(logic [63:0] v);
			logic [63:0] root;
			logic [63:0] trial;
			root = '0;
			for (int b = 31; b >= 0; b--) begin
				trial = root | (64'd1 << b);
				if (trial * trial <= v) root = trial;
			end
			return root;
		endfunction

		function volts_t reading();
			logic [63:0] off;
			logic [63:0] dev;
			logic [63:0] root;
			logic [63:0] prod;
			off = 64'(zero_code);
			dev = 64'(sq_sum) + 64'(WINDOW) * off * off - 64'd2 * off * 64'(lin_sum);
			root = floor_sqrt((dev << 8) / 64'(WINDOW));
			prod = (root * 64'(gain) + 64'd32768) >> 16;
			if (prod > 64'hFFFF) return '1;
			return prod[OUT_W-1:0];
		endfunction

		function void note_sample(sample_t smp, logic report);
			sample_t old;
			old = ring[slot];
			lin_sum = lin_sum - SUM_W'(old) + SUM_W'(smp);
			sq_sum = sq_sum - SQ_W'(old) * SQ_W'(old) + SQ_W'(smp) * SQ_W'(smp);
			ring[slot] = smp;
			slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
			if (report) pending.push_back(reading());
		endfunction

		function void check_reading(volts_t got);
			volts_t want;
			if (pending.size() == 0) begin
				$error("voltage_q4: unexpected transfer, value %0d", got);
				errors++;
			end else begin
				want = pending.pop_front();
				if (got !== want) begin
					$error("voltage_q4: expected %0d, actual %0d", want, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_W-1:0]      m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	volt_scoreboard board;
	int unsigned    samples_sent = 0;
	int unsigned    burst_left = 0;
	int unsigned    cycle_count = 0;
	bit             hold_req = 1'b0;
	int unsigned    hold_left = 0;
	int unsigned    stall_mode = 0;
	int unsigned    mode_left = 0;

	windowed_ac_rms_voltmeter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Output side: checks each transfer and stalls on its own pattern. A hold
	// request from the stimulus keeps tready low for a long stretch.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check_reading(m_tdata);
		if (hold_req && hold_left == 0) begin
			hold_left = HOLD_CYC;
			hold_req = 1'b0;
		end
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(8, 80);
		end else begin
			mode_left--;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYC) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("windowed_ac_rms_voltmeter: mismatch");
		$finish;
	end

	// Offers one sample and waits for its transfer. Between bursts the input
	// goes idle, so tvalid never drops and rises in the same step.
	task automatic send_sample(input sample_t smp, input logic report);
		s_tvalid <= 1'b1;
		s_tdata <= IN_TDATA_W'(smp);
		s_tuser <= report;
		do @(posedge clk); while (!s_tready);
		board.note_sample(smp, report);
		samples_sent++;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
				: $urandom_range(0, 15);
		end else begin
			burst_left--;
		end
	endtask

	// Stops the input and waits until every reading is in, then lets a
	// sample without a report finish before registers change.
	task automatic settle_block();
		if (s_tvalid) s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.write_register(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int        phase_no;
		int        phase_len;
		int        style;
		int        report_div;
		int        center;
		int        amp;
		int        half_period;
		int        pos;
		int        v;
		sample_t   extreme;
		sample_t   smp;
		logic      rep;
		logic [SAMPLE_W-1:0] new_off;
		logic [GAIN_W-1:0]   new_gain;

		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: the first readings see a window that is mostly empty.
		send_sample(12'd0, 1'b1);
		send_sample(12'd4095, 1'b0);
		send_sample(12'd4095, 1'b1);
		send_sample(12'd2948, 1'b1);
		send_sample(12'd0, 1'b0);
		send_sample(12'd1234, 1'b1);
		settle_block();

		// Zero offset at its low end, written with junk above bit 11.
		write_reg(REG_ZERO_OFFSET, 16'hF000);
		write_reg(REG_VOLTS_GAIN, 16'hFFFF);
		send_sample(12'd4095, 1'b1);
		send_sample(12'd0, 1'b1);
		send_sample(12'd4095, 1'b1);
		settle_block();

		write_reg(REG_ZERO_OFFSET, 16'h0FFF);
		write_reg(REG_VOLTS_GAIN, 16'h0000);
		send_sample(12'd0, 1'b1);
		send_sample(12'd4095, 1'b1);
		settle_block();

		// Writes to undecoded indexes must leave both registers alone.
		write_reg(REG_VOLTS_GAIN, 16'd1);
		write_reg(REG_SPARE_2, 16'hA5A5);
		write_reg(REG_SPARE_3, 16'h5A5A);
		send_sample(12'd2048, 1'b1);
		send_sample(12'd1, 1'b0);
		send_sample(12'd4094, 1'b1);
		settle_block();

		phase_no = 0;
		while (samples_sent < ITEM_GOAL) begin
			case ($urandom_range(0, 3))
				0: new_off = '0;
				1: new_off = SAMPLE_W'(SAMPLE_MAX);
				2: new_off = OFFSET_RESET;
				default: new_off = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
			endcase
			case ($urandom_range(0, 3))
				0: new_gain = '0;
				1: new_gain = '1;
				2: new_gain = GAIN_RESET;
				default: new_gain = GAIN_W'($urandom_range(0, 65535));
			endcase
			write_reg(REG_ZERO_OFFSET, {4'($urandom_range(0, 15)), new_off});
			write_reg(REG_VOLTS_GAIN, new_gain);
			if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE_2, 16'($urandom));

			phase_len = $urandom_range(100, 250);
			style = $urandom_range(0, 3);
			report_div = $urandom_range(1, 8);
			center = $urandom_range(0, SAMPLE_MAX);
			amp = $urandom_range(0, 2048);
			half_period = $urandom_range(4, 80);
			extreme = $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
			// One early phase fills the block behind a long output hold.
			if (phase_no == 1) hold_req = 1'b1;

			for (int k = 0; k < phase_len; k++) begin
				case (style)
					0: v = $urandom_range(0, SAMPLE_MAX);
					1: begin
						pos = k % (2 * half_period);
						if (pos >= half_period) pos = 2 * half_period - pos;
						v = center - amp + (2 * amp * pos) / half_period;
					end
					2: v = extreme;
					default: v = center + $urandom_range(0, 64) - 32;
				endcase
				if (v < 0) v = 0;
				if (v > SAMPLE_MAX) v = SAMPLE_MAX;
				smp = SAMPLE_W'(v);
				rep = ($urandom_range(1, report_div) == 1) || (phase_no == 1 && k < 12);
				send_sample(smp, rep);
			end
			settle_block();
			phase_no++;
		end

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("windowed_ac_rms_voltmeter: match");
		end else begin
			$display("windowed_ac_rms_voltmeter: mismatch");
		end
		$finish;
	end

endmodule

@@ windowed_ac_rms_voltmeter.f @@
src/wacrms_pkg.sv
src/wacrms_ram.sv
src/wacrms_ctrl.sv
src/wacrms_dp.sv
src/windowed_ac_rms_voltmeter.sv
verif/tb_windowed_ac_rms_voltmeter.sv
